/* rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Types, opcodes and constants shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned DefMaxTasks = 16;
  localparam int unsigned TimeW       = 17;
  localparam logic [TimeW-1:0] TimeMax = '1;

  // One task arrival
  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  task_priority;
    logic        final_task;
  } in_item_t;

  // One run-chart entry
  typedef struct packed {
    logic [TimeW-1:0] start_time;
    logic [7:0]       run_id;
    logic             end_marker;
    logic             dropped;
    logic             last;
  } out_item_t;

  // Ready table entry
  typedef struct packed {
    logic [7:0]  tid;
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic [15:0] order;
  } entry_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RETIRE,
    OP_EQ_FIN,
    OP_DROP,
    OP_ADMIT_IDLE,
    OP_PREEMPT,
    OP_QUEUE,
    OP_DRAIN,
    OP_MARK,
    OP_CLEAR,
    OP_FLUSH
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RCHK,
    S_RSCAN,
    S_RDO,
    S_ADM,
    S_ASCAN,
    S_ADO,
    S_FIN,
    S_DSCAN,
    S_DDO,
    S_MARK,
    S_CLR,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic run_valid;
    logic f_lt_te;
    logic f_eq_te;
    logic full;
    logic prio_lt_run;
    logic final_task;
    logic scan_done;
    logic found;
    logic emit_ok;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

/* rtl/preemptive_priority_scheduler_top.sv */
// Each arrival scans the table once per retired task, once to admit when idle,
// and once per drained task at the end.
// Throughput: one arrival at a time; the table scan reads one memory entry a cycle.
// Results leave through a one-entry hold buffer and an output register.
// Reset: asynchronous, active low; empties the table and the running task.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Preemptive priority scheduler emitting run-chart entries per arrival.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top #(
  parameter int unsigned MAX_TASKS = pps_pkg::DefMaxTasks
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pps_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pps_pkg::out_item_t  out_data_o
);

  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pps_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: walks one arrival through retire, admit and drain phases.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pps_pkg::status_t  status_i,
  output pps_pkg::cmd_t     cmd_o
);

  pps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o.load       = 1'b0;
    cmd_o.scan_start = 1'b0;
    cmd_o.op         = pps_pkg::OP_NONE;
    in_ready_o       = 1'b0;
    unique case (state_q)
      pps_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pps_pkg::S_RCHK;
        end
      end
      // retire tasks finishing before the arrival
      pps_pkg::S_RCHK: begin
        if (status_i.run_valid && status_i.f_lt_te) begin
          cmd_o.scan_start = 1'b1;
          state_d          = pps_pkg::S_RSCAN;
        end else begin
          if (status_i.run_valid && status_i.f_eq_te) cmd_o.op = pps_pkg::OP_EQ_FIN;
          state_d = pps_pkg::S_ADM;
        end
      end
      pps_pkg::S_RSCAN: begin
        if (status_i.scan_done) state_d = pps_pkg::S_RDO;
      end
      pps_pkg::S_RDO: begin
        if (status_i.emit_ok) begin
          cmd_o.op = pps_pkg::OP_RETIRE;
          state_d  = pps_pkg::S_RCHK;
        end
      end
      // admit, preempt, queue or drop the arrival
      pps_pkg::S_ADM: begin
        if (status_i.full) begin
          if (status_i.emit_ok) begin
            cmd_o.op = pps_pkg::OP_DROP;
            state_d  = pps_pkg::S_FIN;
          end
        end else if (!status_i.run_valid) begin
          cmd_o.scan_start = 1'b1;
          state_d          = pps_pkg::S_ASCAN;
        end else if (status_i.prio_lt_run) begin
          if (status_i.emit_ok) begin
            cmd_o.op = pps_pkg::OP_PREEMPT;
            state_d  = pps_pkg::S_FIN;
          end
        end else begin
          cmd_o.op = pps_pkg::OP_QUEUE;
          state_d  = pps_pkg::S_FIN;
        end
      end
      pps_pkg::S_ASCAN: begin
        if (status_i.scan_done) state_d = pps_pkg::S_ADO;
      end
      pps_pkg::S_ADO: begin
        if (status_i.emit_ok) begin
          cmd_o.op = pps_pkg::OP_ADMIT_IDLE;
          state_d  = pps_pkg::S_FIN;
        end
      end
      // drain on the final arrival
      pps_pkg::S_FIN: begin
        if (!status_i.final_task) begin
          state_d = pps_pkg::S_FLUSH;
        end else if (status_i.run_valid) begin
          cmd_o.scan_start = 1'b1;
          state_d          = pps_pkg::S_DSCAN;
        end else begin
          state_d = pps_pkg::S_MARK;
        end
      end
      pps_pkg::S_DSCAN: begin
        if (status_i.scan_done) state_d = pps_pkg::S_DDO;
      end
      pps_pkg::S_DDO: begin
        if (status_i.emit_ok) begin
          cmd_o.op = pps_pkg::OP_DRAIN;
          state_d  = status_i.found ? pps_pkg::S_FIN : pps_pkg::S_CLR;
        end
      end
      pps_pkg::S_MARK: begin
        if (status_i.emit_ok) begin
          cmd_o.op = pps_pkg::OP_MARK;
          state_d  = pps_pkg::S_CLR;
        end
      end
      pps_pkg::S_CLR: begin
        cmd_o.op = pps_pkg::OP_CLEAR;
        state_d  = pps_pkg::S_FLUSH;
      end
      // push the held result out with its last flag
      pps_pkg::S_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = pps_pkg::S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op = pps_pkg::OP_FLUSH;
          state_d  = pps_pkg::S_IDLE;
        end
      end
      default: state_d = pps_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/pps_dp.sv */
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: running task, ready table memory, scan unit and result buffers.
// ----------------------------------------------------------------------------
module pps_dp #(
  parameter int unsigned MAX_TASKS = pps_pkg::DefMaxTasks
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pps_pkg::in_item_t   in_data_i,
  input  pps_pkg::cmd_t       cmd_i,
  output pps_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pps_pkg::out_item_t  out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned TW   = pps_pkg::TimeW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TASKS - 1);

  // ready table
  pps_pkg::entry_t     mem [MAX_TASKS];
  pps_pkg::entry_t     mem_rd_q;
  logic [MAX_TASKS-1:0] valid_q, valid_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                we;
  logic [IdxW-1:0]     waddr;
  pps_pkg::entry_t     wdata;

  // current item and running task
  pps_pkg::in_item_t   item_q;
  pps_pkg::in_item_t   in_fix;
  logic [TW-1:0]       te_q;
  logic                rv_q, rv_d;
  pps_pkg::entry_t     run_q, run_d;
  logic [TW-1:0]       seg_q, seg_d;
  logic [15:0]         acnt_q, acnt_d;

  // scan unit
  logic                sc_busy_q;
  logic [IdxW-1:0]     sc_addr_q;
  logic                rd_v_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic                found_q;
  logic [IdxW-1:0]     best_idx_q;
  pps_pkg::entry_t     best_q;

  // result buffers
  logic                pend_v_q, pend_v_d;
  pps_pkg::out_item_t  pend_q, pend_d;
  logic                out_v_q, out_v_d;
  pps_pkg::out_item_t  out_q, out_d;

  logic [TW:0]         sum;
  logic [TW-1:0]       fin_t;
  logic [TW-1:0]       t_ext;
  logic [TW-1:0]       elapsed;
  logic [IdxW-1:0]     free_idx;
  logic                out_free;
  logic                emit;
  pps_pkg::out_item_t  emit_item;
  pps_pkg::entry_t     new_entry;

  // finish time of the running task, saturated
  assign sum   = {1'b0, seg_q} + (TW+1)'(run_q.remaining);
  assign fin_t = sum[TW] ? pps_pkg::TimeMax : sum[TW-1:0];
  assign t_ext = TW'(in_data_i.arrival_time);
  assign elapsed = te_q - seg_q;

  assign new_entry = '{tid: item_q.task_id, prio: item_q.task_priority,
                       remaining: item_q.burst_length, order: acnt_q};

  // incoming item, zero burst taken as one tick
  always_comb begin
    in_fix = in_data_i;
    if (in_data_i.burst_length == '0) in_fix.burst_length = 16'd1;
  end

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IdxW'(i);
    end
  end

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    status_o.run_valid   = rv_q;
    status_o.f_lt_te     = fin_t < te_q;
    status_o.f_eq_te     = fin_t == te_q;
    status_o.full        = (CntW'(rv_q) + cnt_q) >= CntW'(MAX_TASKS);
    status_o.prio_lt_run = item_q.task_priority < run_q.prio;
    status_o.final_task  = item_q.final_task;
    status_o.scan_done   = rd_v_q && (rd_idx_q == LastIdx);
    status_o.found       = found_q;
    status_o.emit_ok     = !pend_v_q || out_free;
    status_o.pend_valid  = pend_v_q;
    status_o.out_free    = out_free;
  end

  // operation decode
  always_comb begin
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    rv_d      = rv_q;
    run_d     = run_q;
    seg_d     = seg_q;
    acnt_d    = acnt_q;
    we        = 1'b0;
    waddr     = free_idx;
    wdata     = new_entry;
    emit      = 1'b0;
    emit_item = '{start_time: te_q, run_id: item_q.task_id, end_marker: 1'b0,
                  dropped: 1'b0, last: 1'b0};
    unique case (cmd_i.op) inside
      pps_pkg::OP_NONE, pps_pkg::OP_FLUSH: ;
      pps_pkg::OP_RETIRE, pps_pkg::OP_DRAIN: begin
        emit_item.start_time = fin_t;
        if (found_q) begin
          run_d              = best_q;
          valid_d[best_idx_q] = 1'b0;
          cnt_d              = cnt_q - CntW'(1);
          seg_d              = fin_t;
          emit               = 1'b1;
          emit_item.run_id   = best_q.tid;
        end else begin
          rv_d  = 1'b0;
          seg_d = fin_t;
          if (cmd_i.op == pps_pkg::OP_DRAIN) begin
            emit                 = 1'b1;
            emit_item.run_id     = '0;
            emit_item.end_marker = 1'b1;
          end
        end
      end
      pps_pkg::OP_EQ_FIN: begin
        rv_d  = 1'b0;
        seg_d = te_q;
      end
      pps_pkg::OP_DROP: begin
        emit              = 1'b1;
        emit_item.dropped = 1'b1;
      end
      pps_pkg::OP_ADMIT_IDLE: begin
        acnt_d = acnt_q + 16'd1;
        rv_d   = 1'b1;
        seg_d  = te_q;
        emit   = 1'b1;
        if (found_q && (best_q.prio <= item_q.task_priority)) begin
          run_d            = best_q;
          we               = 1'b1;
          waddr            = best_idx_q;
          emit_item.run_id = best_q.tid;
        end else begin
          run_d = new_entry;
        end
      end
      pps_pkg::OP_PREEMPT: begin
        acnt_d          = acnt_q + 16'd1;
        we              = 1'b1;
        wdata           = run_q;
        wdata.remaining = run_q.remaining - elapsed[15:0];
        valid_d[free_idx] = 1'b1;
        cnt_d           = cnt_q + CntW'(1);
        run_d           = new_entry;
        seg_d           = te_q;
        emit            = 1'b1;
      end
      pps_pkg::OP_QUEUE: begin
        acnt_d            = acnt_q + 16'd1;
        we                = 1'b1;
        valid_d[free_idx] = 1'b1;
        cnt_d             = cnt_q + CntW'(1);
      end
      pps_pkg::OP_MARK: begin
        emit                 = 1'b1;
        emit_item.start_time = seg_q;
        emit_item.run_id     = '0;
        emit_item.end_marker = 1'b1;
      end
      pps_pkg::OP_CLEAR: begin
        valid_d = '0;
        cnt_d   = '0;
        rv_d    = 1'b0;
        run_d   = '0;
        seg_d   = '0;
        acnt_d  = '0;
      end
      default: ;
    endcase
  end

  // hold one result back so the last flag can be set at the end
  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    if (emit) begin
      pend_v_d = 1'b1;
      pend_d   = emit_item;
      if (pend_v_q) begin
        out_v_d = 1'b1;
        out_d   = pend_q;
      end
    end else if (cmd_i.op == pps_pkg::OP_FLUSH) begin
      pend_v_d    = 1'b0;
      out_v_d     = 1'b1;
      out_d       = pend_q;
      out_d.last  = 1'b1;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    mem_rd_q <= mem[sc_addr_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_fix;
      te_q   <= (t_ext < seg_q) ? seg_q : t_ext;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
    if (rd_v_q && valid_q[rd_idx_q] &&
        (!found_q || (mem_rd_q.prio < best_q.prio) ||
         ((mem_rd_q.prio == best_q.prio) && (mem_rd_q.order < best_q.order)))) begin
      best_q     <= mem_rd_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // control and task state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      run_q     <= '0;
      seg_q     <= '0;
      acnt_q    <= '0;
      sc_busy_q <= 1'b0;
      sc_addr_q <= '0;
      rd_v_q    <= 1'b0;
      rd_idx_q  <= '0;
      found_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
      rv_q     <= rv_d;
      run_q    <= run_d;
      seg_q    <= seg_d;
      acnt_q   <= acnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      // scan: one entry read per cycle, compared in the cycle after its read
      rd_v_q   <= sc_busy_q;
      rd_idx_q <= sc_addr_q;
      if (cmd_i.scan_start) begin
        sc_busy_q <= 1'b1;
        sc_addr_q <= '0;
        found_q   <= 1'b0;
      end else begin
        if (sc_busy_q) begin
          if (sc_addr_q == LastIdx) sc_busy_q <= 1'b0;
          else sc_addr_q <= sc_addr_q + IdxW'(1);
        end
        if (rd_v_q && valid_q[rd_idx_q]) found_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

/* sim/tb_preemptive_priority_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_top
// Drives batches of task arrivals into the scheduler and checks every
// run-chart entry against a cycle-free model of the scheduling rules.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_top;

  localparam int unsigned NumSlots = pps_pkg::DefMaxTasks;
  localparam int unsigned TickMax  = 131071;

  // Run-chart predictor and expected-entry store
  class chart_scoreboard;
    bit          slot_used [NumSlots];
    logic [7:0]  slot_tid  [NumSlots];
    logic [7:0]  slot_prio [NumSlots];
    int unsigned slot_left [NumSlots];
    int unsigned slot_seq  [NumSlots];
    bit          cur_busy;
    logic [7:0]  cur_tid;
    logic [7:0]  cur_prio;
    int unsigned cur_left;
    int unsigned cur_seq;
    int unsigned seg_start;
    int unsigned admit_seq;
    pps_pkg::out_item_t chart_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      cur_busy  = 1'b0;
      cur_tid   = '0;
      cur_prio  = '0;
      cur_left  = 0;
      cur_seq   = 0;
      seg_start = 0;
      admit_seq = 0;
    endfunction

    function int unsigned finish_tick();
      int unsigned s;
      s = seg_start + cur_left;
      return (s > TickMax) ? TickMax : s;
    endfunction

    // Best ready entry: lowest priority value, then oldest stamp, then lowest slot
    function int best_slot();
      int b;
      b = -1;
      for (int i = 0; i < NumSlots; i++) begin
        if (!slot_used[i]) continue;
        if (b < 0 || slot_prio[i] < slot_prio[b] ||
            (slot_prio[i] == slot_prio[b] && slot_seq[i] < slot_seq[b])) b = i;
      end
      return b;
    endfunction

    function int free_slot();
      for (int i = 0; i < NumSlots; i++)
        if (!slot_used[i]) return i;
      return -1;
    endfunction

    function void run_slot(int j, int unsigned t);
      cur_tid   = slot_tid[j];
      cur_prio  = slot_prio[j];
      cur_left  = slot_left[j];
      cur_seq   = slot_seq[j];
      slot_used[j] = 1'b0;
      cur_busy  = 1'b1;
      seg_start = t;
    endfunction

    function void park(int j, logic [7:0] id, logic [7:0] pr, int unsigned left,
                       int unsigned sq);
      slot_used[j] = 1'b1;
      slot_tid[j]  = id;
      slot_prio[j] = pr;
      slot_left[j] = left;
      slot_seq[j]  = sq;
    endfunction

    function void add_entry(int unsigned t, logic [7:0] id, bit mark, bit drop);
      pps_pkg::out_item_t e;
      e.start_time = t[pps_pkg::TimeW-1:0];
      e.run_id     = id;
      e.end_marker = mark;
      e.dropped    = drop;
      e.last       = 1'b0;
      chart_q.insert(chart_q.size(), e);
    endfunction

    // Accepted arrival: work out the chart entries it causes
    function void note_arrival(pps_pkg::in_item_t a);
      int unsigned burst, te, f, sq;
      int j, occ, n0;
      bit marked;
      n0    = chart_q.size();
      burst = (a.burst_length == 0) ? 1 : a.burst_length;
      te    = (a.arrival_time < seg_start) ? seg_start : a.arrival_time;

      // retire tasks finishing strictly before the arrival
      while (cur_busy) begin
        f = finish_tick();
        if (f >= te) break;
        j = best_slot();
        if (j >= 0) begin
          run_slot(j, f);
          add_entry(f, cur_tid, 0, 0);
        end else begin
          cur_busy  = 1'b0;
          seg_start = f;
        end
      end
      // equal finish: retire silently, the arrival competes at this tick
      if (cur_busy && finish_tick() == te) begin
        cur_busy  = 1'b0;
        seg_start = te;
      end

      occ = cur_busy ? 1 : 0;
      foreach (slot_used[i]) if (slot_used[i]) occ++;

      if (occ >= NumSlots) begin
        add_entry(te, a.task_id, 0, 1);
      end else begin
        sq = admit_seq;
        admit_seq = (admit_seq + 1) & 16'hFFFF;
        if (!cur_busy) begin
          j = best_slot();
          if (j >= 0 && slot_prio[j] <= a.task_priority) begin
            run_slot(j, te);
            park(j, a.task_id, a.task_priority, burst, sq);
          end else begin
            cur_busy  = 1'b1;
            cur_tid   = a.task_id;
            cur_prio  = a.task_priority;
            cur_left  = burst;
            cur_seq   = sq;
            seg_start = te;
          end
          add_entry(te, cur_tid, 0, 0);
        end else if (a.task_priority < cur_prio) begin
          j = free_slot();
          if (j >= 0) begin
            park(j, cur_tid, cur_prio, cur_left - (te - seg_start), cur_seq);
            cur_tid   = a.task_id;
            cur_prio  = a.task_priority;
            cur_left  = burst;
            cur_seq   = sq;
            seg_start = te;
            add_entry(te, a.task_id, 0, 0);
          end
        end else begin
          j = free_slot();
          if (j >= 0) park(j, a.task_id, a.task_priority, burst, sq);
        end
      end

      // final arrival drains the table and closes with the end marker
      if (a.final_task) begin
        marked = 1'b0;
        while (cur_busy) begin
          f = finish_tick();
          j = best_slot();
          if (j >= 0) begin
            run_slot(j, f);
            add_entry(f, cur_tid, 0, 0);
          end else begin
            cur_busy = 1'b0;
            add_entry(f, 8'd0, 1, 0);
            marked = 1'b1;
          end
        end
        if (!marked) add_entry(seg_start, 8'd0, 1, 0);
        clear_state();
      end

      if (chart_q.size() > n0) chart_q[$].last = 1'b1;
    endfunction

    // Accepted chart entry: compare with the oldest expectation
    function void check_result(pps_pkg::out_item_t got);
      pps_pkg::out_item_t w;
      if (chart_q.size() == 0) begin
        $display("%0t: unexpected entry, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      w = chart_q[0];
      chart_q.delete(0);
      if (got.start_time !== w.start_time) begin
        $display("%0t: start_time expected %0d actual %0d", $realtime, w.start_time,
                 got.start_time);
        errors++;
      end
      if (got.run_id !== w.run_id) begin
        $display("%0t: run_id expected %0d actual %0d", $realtime, w.run_id, got.run_id);
        errors++;
      end
      if (got.end_marker !== w.end_marker) begin
        $display("%0t: end_marker expected %0b actual %0b", $realtime, w.end_marker,
                 got.end_marker);
        errors++;
      end
      if (got.dropped !== w.dropped) begin
        $display("%0t: dropped expected %0b actual %0b", $realtime, w.dropped, got.dropped);
        errors++;
      end
      if (got.last !== w.last) begin
        $display("%0t: last expected %0b actual %0b", $realtime, w.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return chart_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  pps_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  pps_pkg::out_item_t out_data_o;

  chart_scoreboard sb;
  bit quiet;      // no idling in the closing part
  bit hold_req;   // receiver long hold-off request
  int sent;

  preemptive_priority_scheduler_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Transfer monitor: checks results, then records accepted arrivals
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_arrival(in_data_i);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one arrival and wait for its transfer
  task automatic send_arrival(logic [7:0] id, int unsigned t, int unsigned burst,
                              logic [7:0] pr, bit fin);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{task_id: id, arrival_time: t[15:0], burst_length: burst[15:0],
                    task_priority: pr, final_task: fin};
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One batch of time-ordered arrivals ending with the final one;
  // a few items are malformed (time going back, odd bursts)
  task automatic run_batch(int n, int unsigned step_max, int unsigned burst_max,
                           int unsigned prio_max, bit gaps);
    int unsigned t, b;
    t = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
    for (int k = 0; k < n; k++) begin
      t += $urandom_range(0, step_max);
      if (t > 65535) t = 65535;
      case ($urandom_range(0, 19))
        0:       b = 0;
        1:       b = 65535;
        2:       b = $urandom_range(0, 65535);
        default: b = $urandom_range(1, burst_max);
      endcase
      send_arrival(8'($urandom_range(0, 255)),
                   ($urandom_range(0, 19) == 0) ? $urandom_range(0, t) : t,
                   b, 8'($urandom_range(0, prio_max)), k == n - 1);
      if (gaps) maybe_gap();
    end
  endtask

  initial begin
    sb          = new();
    quiet       = 1'b0;
    hold_req    = 1'b0;
    sent        = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero and maximal bursts, same-tick preemption, priority tie, late final
    send_arrival(8'd0,   0, 0,     8'd255, 1'b0);
    send_arrival(8'd255, 0, 65535, 8'd0,   1'b0);
    send_arrival(8'd7,   5, 3,     8'd0,   1'b0);
    send_arrival(8'd9,   65535, 65535, 8'd128, 1'b1);
    // equal finish at tick 15, then an idle gap before tick 40
    send_arrival(8'd1, 10, 5, 8'd3, 1'b0);
    send_arrival(8'd2, 15, 2, 8'd3, 1'b0);
    send_arrival(8'd3, 40, 1, 8'd1, 1'b0);
    send_arrival(8'd4, 40, 1, 8'd1, 1'b1);
    // full table: the last arrival is dropped
    for (int k = 0; k < 17; k++)
      send_arrival(k[7:0] + 8'd100, 100, 1000, 8'd50, k == 16);

    // random batches, mostly well formed
    while (sent < 200) begin
      case ($urandom_range(0, 3))
        0:       run_batch($urandom_range(1, 6), 50, 40, 255, 1'b1);
        1:       run_batch($urandom_range(2, 20), 20, 60, 7, 1'b1);
        2:       run_batch($urandom_range(15, 24), 3, 400, 3, 1'b1);
        default: run_batch($urandom_range(3, 12), 500, 300, 255, 1'b1);
      endcase
    end

    // long receiver hold-off while arrivals keep coming, then a full pause
    hold_req = 1'b1;
    run_batch(30, 2, 20, 15, 1'b0);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();

    while (sent < 400) begin
      if ($urandom_range(0, 1)) run_batch($urandom_range(2, 20), 20, 60, 7, 1'b1);
      else                      run_batch($urandom_range(15, 22), 2, 500, 255, 1'b1);
    end

    quiet = 1'b1;
    while (sent < 470) run_batch($urandom_range(2, 18), 10, 30, 7, 1'b0);
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb_preemptive_priority_scheduler_top: done, clean");
    else
      $display("tb_preemptive_priority_scheduler_top: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("tb_preemptive_priority_scheduler_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/pps_pkg.sv
rtl/pps_ctrl.sv
rtl/pps_dp.sv
rtl/preemptive_priority_scheduler_top.sv
sim/tb_preemptive_priority_scheduler_top.sv
